[rtl/core/wmtp_pkg.sv]
// Shared types, constants and byte-class helpers for the markup tag parser.
// No dependencies; imported by wmtp_scan, wiki_markup_tag_parser_core and the testbench.
package wmtp_pkg;

  localparam int unsigned WMTP_MAX_LEN = 1024;

  localparam int unsigned FLD_W = 10;   // offset and length fields
  localparam int unsigned TOT_W = 11;   // total tag length

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [2:0] {
    PH_DONE  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_SKIP1 = 3'd2,
    PH_KEY   = 3'd3,
    PH_SKIP2 = 3'd4,
    PH_ARGS  = 3'd5
  } phase_t;

  typedef struct packed {
    logic             matched;
    logic [FLD_W-1:0] type_len;
    logic [FLD_W-1:0] key_start;
    logic [FLD_W-1:0] key_len;
    logic [FLD_W-1:0] args_start;
    logic [FLD_W-1:0] args_len;
    logic [TOT_W-1:0] total_len;
  } scan_res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

[rtl/core/wiki_markup_tag_parser_core.sv]
// Markup tag parser: one text byte per beat in, one result beat per decided candidate.
// Each byte is registered, decided by the scan, and its result registered before out_tvalid rises.
// Input takes one byte per cycle while no result waits; the scan state updates once per byte in wmtp_scan.
// A waiting result holds the scan stage; the input register still takes one more byte,
// then in_tready drops until the result beat goes. Reset (rst_n low, synchronous) empties
// both registers and leaves the scanner idle until a beat with the first flag arrives.
module wiki_markup_tag_parser_core #(
  parameter int unsigned MAX_LEN = wmtp_pkg::WMTP_MAX_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tuser,   // [0] first
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [9:0] type_len, [19:10] key_start, [29:20] key_len,
                                  // [39:30] args_start, [49:40] args_len,
                                  // [60:50] total_len, [63:61] zero
  output logic        out_tuser   // [0] matched
);
  import wmtp_pkg::*;

  logic       s0_valid_r, s0_valid_nxt;
  logic [7:0] s0_byte_r;
  logic       s0_first_r;
  logic       in_fire, advance, s0_fire;

  logic       scan_emit;
  scan_res_t  scan_res;

  logic       out_valid_r, out_valid_nxt;
  scan_res_t  out_res_r;

  // the scan stage moves whenever the result register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign s0_fire   = s0_valid_r && advance;
  assign in_tready = !s0_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign s0_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s0_valid_r);
  assign out_valid_nxt = advance ? (s0_fire && scan_emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_byte_r  <= in_tdata;
      s0_first_r <= in_tuser;
    end
  end

  wmtp_scan #(
    .MAX_LEN (MAX_LEN)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s0_fire),
    .char_byte (s0_byte_r),
    .first     (s0_first_r),
    .emit      (scan_emit),
    .res       (scan_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && scan_emit) begin
      out_res_r <= scan_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.matched;
  assign out_tdata  = {3'b000, out_res_r.total_len, out_res_r.args_len,
                       out_res_r.args_start, out_res_r.key_len,
                       out_res_r.key_start, out_res_r.type_len};

`ifndef SYNTHESIS
  // a failed candidate carries all-zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.matched) |-> (out_tdata == 64'd0))
    else $error("failure result with non-zero fields");

  // input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s0_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  // a first byte other than an opening brace yields an immediate failure beat
  a_bad_open: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && s0_first_r && (s0_byte_r != CH_LBRACE)) |=>
      (out_valid_r && !out_res_r.matched))
    else $error("missing failure for bad opening byte");
`endif

endmodule

[rtl/core/wmtp_scan.sv]
// Scan state machine and per-byte datapath of the markup tag parser.
// Holds phase, position, nesting depth and saved offsets; uses wmtp_pkg.
module wmtp_scan #(
  parameter int unsigned MAX_LEN = wmtp_pkg::WMTP_MAX_LEN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          char_byte,
  input  logic                first,
  output logic                emit,
  output wmtp_pkg::scan_res_t res
);
  import wmtp_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LEN + 1);

  phase_t           phase_r, phase_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [PW-1:0]    depth_r, depth_nxt;
  logic [FLD_W-1:0] stl_r, stl_nxt;
  logic [FLD_W-1:0] sks_r, sks_nxt;
  logic [FLD_W-1:0] skl_r, skl_nxt;
  logic [FLD_W-1:0] sas_r, sas_nxt;

  logic             is_obr, is_cbr, is_colon, is_stop, letter, blank;
  logic             too_long, closes;
  logic [31:0]      pos_w, pos_p1;
  logic [FLD_W-1:0] i_f;
  logic [TOT_W-1:0] tot;

  assign is_obr   = (char_byte == CH_LBRACE);
  assign is_cbr   = (char_byte == CH_RBRACE);
  assign is_colon = (char_byte == CH_COLON);
  assign is_stop  = (char_byte == CH_NEWLINE) || (char_byte == CH_NUL);
  assign letter   = is_letter(char_byte);
  assign blank    = is_blank(char_byte);
  assign too_long = (pos_r >= PW'(MAX_LEN));
  // depth only rises on '{', so a '}' at depth one is the only close
  assign closes   = is_cbr && (depth_r == PW'(1));

  assign pos_w  = 32'(pos_r);
  assign pos_p1 = pos_w + 32'd1;
  assign i_f    = pos_w[FLD_W-1:0];
  assign tot    = pos_p1[TOT_W-1:0];

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (first) begin
      phase_nxt = is_obr ? PH_TYPE : PH_DONE;
    end else if (phase_r != PH_DONE) begin
      if (too_long) begin
        phase_nxt = PH_DONE;
      end else begin
        unique case (phase_r)
          PH_TYPE: begin
            if (letter)        phase_nxt = PH_TYPE;
            else if (is_colon) phase_nxt = PH_SKIP1;
            else               phase_nxt = PH_DONE;
          end
          PH_SKIP1: begin
            if (is_stop)     phase_nxt = PH_DONE;
            else if (blank)  phase_nxt = PH_SKIP1;
            else if (closes) phase_nxt = PH_DONE;
            else             phase_nxt = PH_KEY;
          end
          PH_KEY: begin
            if (is_stop)     phase_nxt = PH_DONE;
            else if (blank)  phase_nxt = PH_SKIP2;
            else if (closes) phase_nxt = PH_DONE;
            else             phase_nxt = PH_KEY;
          end
          PH_SKIP2: begin
            if (is_stop)     phase_nxt = PH_DONE;
            else if (blank)  phase_nxt = PH_SKIP2;
            else if (closes) phase_nxt = PH_DONE;
            else             phase_nxt = PH_ARGS;
          end
          PH_ARGS: begin
            if (is_stop || closes) phase_nxt = PH_DONE;
            else                   phase_nxt = PH_ARGS;
          end
          default: phase_nxt = PH_DONE;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    pos_nxt   = pos_r;
    depth_nxt = depth_r;
    stl_nxt   = stl_r;
    sks_nxt   = sks_r;
    skl_nxt   = skl_r;
    sas_nxt   = sas_r;
    emit      = 1'b0;
    res       = '0;
    if (first) begin
      pos_nxt   = PW'(1);
      depth_nxt = PW'(1);
      stl_nxt   = '0;
      sks_nxt   = '0;
      skl_nxt   = '0;
      sas_nxt   = '0;
      emit      = !is_obr;
    end else if (phase_r != PH_DONE) begin
      if (too_long) begin
        emit = 1'b1;
      end else begin
        pos_nxt = pos_p1[PW-1:0];
        // nesting is tracked on every non-blank byte in key/args phases
        if (((phase_r == PH_SKIP1 || phase_r == PH_SKIP2) && !is_stop && !blank) ||
            (phase_r == PH_KEY && !is_stop && !blank) ||
            (phase_r == PH_ARGS && !is_stop)) begin
          if (is_cbr)      depth_nxt = depth_r - PW'(1);
          else if (is_obr) depth_nxt = depth_r + PW'(1);
        end
        case (phase_r)
          PH_TYPE: begin
            if (is_cbr) begin
              emit           = 1'b1;
              res.matched    = 1'b1;
              res.type_len   = i_f - FLD_W'(1);
              res.key_start  = FLD_W'(1);
              res.key_len    = i_f - FLD_W'(1);
              res.args_start = FLD_W'(1);
              res.args_len   = i_f - FLD_W'(1);
              res.total_len  = tot;
            end else if (is_colon) begin
              stl_nxt = i_f - FLD_W'(1);
            end else if (!letter) begin
              emit = 1'b1;
            end
          end
          PH_SKIP1: begin
            if (is_stop) begin
              emit = 1'b1;
            end else if (!blank) begin
              sks_nxt = i_f;
              if (closes) begin
                emit           = 1'b1;
                res.matched    = 1'b1;
                res.type_len   = stl_r;
                res.key_start  = i_f;
                res.args_start = i_f;
                res.total_len  = tot;
              end
            end
          end
          PH_KEY: begin
            if (is_stop) begin
              emit = 1'b1;
            end else if (blank) begin
              skl_nxt = i_f - sks_r;
            end else if (closes) begin
              emit           = 1'b1;
              res.matched    = 1'b1;
              res.type_len   = stl_r;
              res.key_start  = sks_r;
              res.key_len    = i_f - sks_r;
              res.args_start = sks_r;
              res.args_len   = i_f - sks_r;
              res.total_len  = tot;
            end
          end
          PH_SKIP2: begin
            if (is_stop) begin
              emit = 1'b1;
            end else if (!blank) begin
              sas_nxt = i_f;
              if (closes) begin
                emit           = 1'b1;
                res.matched    = 1'b1;
                res.type_len   = stl_r;
                res.key_start  = sks_r;
                res.key_len    = skl_r;
                res.args_start = i_f;
                res.total_len  = tot;
              end
            end
          end
          PH_ARGS: begin
            if (is_stop) begin
              emit = 1'b1;
            end else if (closes) begin
              emit           = 1'b1;
              res.matched    = 1'b1;
              res.type_len   = stl_r;
              res.key_start  = sks_r;
              res.key_len    = skl_r;
              res.args_start = sas_r;
              res.args_len   = i_f - sas_r;
              res.total_len  = tot;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      pos_r   <= '0;
      depth_r <= PW'(1);
      stl_r   <= '0;
      sks_r   <= '0;
      skl_r   <= '0;
      sas_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      depth_r <= depth_nxt;
      stl_r   <= stl_nxt;
      sks_r   <= sks_nxt;
      skl_r   <= skl_nxt;
      sas_r   <= sas_nxt;
    end
  end

endmodule

[tb/wmtp_checker.sv]
// Scoreboard for the markup tag parser: watches both stream channels, predicts each decision.
// Depends on wmtp_pkg (phase enum, byte constants, length limit); instantiated by tb_top.
module wmtp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  output int unsigned err_count,
  output int unsigned pending,
  output int unsigned results_seen,
  output int unsigned tags_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import wmtp_pkg::*;

  typedef struct {
    bit        matched;
    bit [9:0]  type_len;
    bit [9:0]  key_start;
    bit [9:0]  key_len;
    bit [9:0]  args_start;
    bit [9:0]  args_len;
    bit [10:0] total_len;
  } tag_res_t;

  tag_res_t    due_q[$];
  phase_t      phase;
  int unsigned pos;
  bit [31:0]   depth;
  int unsigned sv_type_len, sv_key_start, sv_key_len, sv_args_start;

  initial begin
    err_count    = 0;
    pending      = 0;
    results_seen = 0;
    tags_seen    = 0;
  end

  function automatic bit alpha_byte(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit space_byte(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit stop_byte(input logic [7:0] c);
    return c == CH_NEWLINE || c == CH_NUL;
  endfunction

  // brace nesting inside key/args; true once the opening brace is closed
  function automatic bit nest_done(input logic [7:0] c);
    if (c == CH_RBRACE) depth = depth - 1;
    if (c == CH_LBRACE) depth = depth + 1;
    return depth == 0;
  endfunction

  task automatic decide(input bit m, input int unsigned tl, input int unsigned ks,
                        input int unsigned kl, input int unsigned as,
                        input int unsigned al, input int unsigned tot);
    tag_res_t r;
    begin
      r.matched    = m;
      r.type_len   = tl[9:0];
      r.key_start  = ks[9:0];
      r.key_len    = kl[9:0];
      r.args_start = as[9:0];
      r.args_len   = al[9:0];
      r.total_len  = tot[10:0];
      due_q.push_back(r);
      phase = PH_DONE;
    end
  endtask

  task automatic no_tag();
    decide(1'b0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic f);
    int unsigned i;
    begin
      if (f) begin
        pos           = 1;
        depth         = 1;
        sv_type_len   = 0;
        sv_key_start  = 0;
        sv_key_len    = 0;
        sv_args_start = 0;
        if (c != CH_LBRACE) no_tag();
        else phase = PH_TYPE;
        return;
      end
      if (phase == PH_DONE) return;
      i = pos;
      if (i >= WMTP_MAX_LEN) begin
        no_tag();
        return;
      end
      pos = i + 1;
      case (phase)
        PH_TYPE: begin
          if (alpha_byte(c)) ;
          else if (c == CH_RBRACE) decide(1'b1, i - 1, 1, i - 1, 1, i - 1, i + 1);
          else if (c != CH_COLON) no_tag();
          else begin
            sv_type_len = i - 1;
            phase       = PH_SKIP1;
          end
        end
        PH_SKIP1: begin
          if (stop_byte(c)) no_tag();
          else if (!space_byte(c)) begin
            sv_key_start = i;
            phase        = PH_KEY;
            if (nest_done(c)) decide(1'b1, sv_type_len, i, 0, i, 0, i + 1);
          end
        end
        PH_KEY: begin
          if (stop_byte(c)) no_tag();
          else if (space_byte(c)) begin
            sv_key_len = i - sv_key_start;
            phase      = PH_SKIP2;
          end else if (nest_done(c)) begin
            decide(1'b1, sv_type_len, sv_key_start, i - sv_key_start, sv_key_start,
                   i - sv_key_start, i + 1);
          end
        end
        PH_SKIP2: begin
          if (stop_byte(c)) no_tag();
          else if (!space_byte(c)) begin
            sv_args_start = i;
            phase         = PH_ARGS;
            if (nest_done(c))
              decide(1'b1, sv_type_len, sv_key_start, sv_key_len, i, 0, i + 1);
          end
        end
        PH_ARGS: begin
          if (stop_byte(c)) no_tag();
          else if (nest_done(c))
            decide(1'b1, sv_type_len, sv_key_start, sv_key_len, sv_args_start,
                   i - sv_args_start, i + 1);
        end
        default: phase = PH_DONE;
      endcase
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_beat();
    tag_res_t want;
    begin
      if (due_q.size() == 0) begin
        err_count++;
        $display("%0t ns: unexpected result beat, expected none, actual tuser=%0h tdata=%h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = due_q.pop_front();
        results_seen++;
        if (want.matched) tags_seen++;
        check_field("matched",    want.matched,    out_tuser);
        check_field("type_len",   want.type_len,   out_tdata[9:0]);
        check_field("key_start",  want.key_start,  out_tdata[19:10]);
        check_field("key_len",    want.key_len,    out_tdata[29:20]);
        check_field("args_start", want.args_start, out_tdata[39:30]);
        check_field("args_len",   want.args_len,   out_tdata[49:40]);
        check_field("total_len",  want.total_len,  out_tdata[60:50]);
        check_field("tdata pad",  0,               out_tdata[63:61]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase         = PH_DONE;
      pos           = 0;
      depth         = 1;
      sv_type_len   = 0;
      sv_key_start  = 0;
      sv_key_len    = 0;
      sv_args_start = 0;
      due_q.delete();
    end else begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) check_beat();
    end
    pending = due_q.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the markup tag parser bench: clock, reset, byte stimulus and result back-pressure.
// Depends on wmtp_pkg, wiki_markup_tag_parser_core and wmtp_checker (prediction and compare).
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wmtp_pkg::*;

  // shape of a generated candidate
  typedef enum int unsigned {FORM_BARE, FORM_KEY, FORM_KEY_ARGS} tag_form_t;
  // receiver stall styles, each held for a random stretch
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_TIGHT, RX_PULSE} rx_pace_t;

  localparam int unsigned TEXT_BYTES = 1100;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] char_byte
  logic        in_tuser;   // [0] first
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [9:0] type_len .. [60:50] total_len, [63:61] zero
  logic        out_tuser;  // [0] matched

  int unsigned err_count, pending, results_seen, tags_seen;

  logic [7:0]  txt[$];      // candidate being built
  int unsigned burst_left;  // beats left before the sender may idle
  int unsigned beats_sent;
  bit          steady;      // no sender gaps while set

  wiki_markup_tag_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  wmtp_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .err_count    (err_count),
    .pending      (pending),
    .results_seen (results_seen),
    .tags_seen    (tags_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest honest run sends about 3300 beats, each at worst
  // a result held by the tight stall pattern plus a sender gap; the
  // timeout allows well over ten times that run.
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  // Receiver: stall style changes after each random stretch so gaps land on
  // every phase of the scan, with open stretches in between.
  initial begin : rx_side
    rx_pace_t    pace;
    int unsigned stretch;
    int unsigned tick;
    pace       = RX_OPEN;
    stretch    = 0;
    tick       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        pace    = rx_pace_t'($urandom_range(0, 3));
        stretch = $urandom_range(32, 256);
      end
      stretch--;
      tick++;
      case (pace)
        RX_OPEN:  out_tready = 1'b1;
        RX_COIN:  out_tready = 1'($urandom_range(0, 1));
        RX_TIGHT: out_tready = ($urandom_range(0, 3) == 0);
        default:  out_tready = ((tick % 7) < 3);
      endcase
    end
  end

  function automatic logic [7:0] letter();
    if ($urandom_range(0, 1)) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  // any byte that may sit inside a key without ending it or nesting
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h21, 8'hFF));
    while (b == CH_LBRACE || b == CH_RBRACE);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    logic [7:0] b;
    if ($urandom_range(0, 1)) return CH_SPACE;
    do b = 8'($urandom_range(CH_TAB, CH_CR));
    while (b == CH_NEWLINE);
    return b;
  endfunction

  // Drive one beat and hold it until taken. Called and returns at a
  // falling edge; tvalid is only dropped when a gap follows, so it is
  // never lowered and raised within one step.
  task automatic put_byte(input logic [7:0] b, input logic f);
    int unsigned gap;
    begin
      in_tvalid = 1'b1;
      in_tdata  = b;
      in_tuser  = f;
      do @(posedge clk);
      while (!in_tready);
      @(negedge clk);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (!steady) begin
          gap       = $urandom_range(1, 6);
          in_tvalid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_txt();
    for (int k = 0; k < txt.size(); k++) put_byte(txt[k], k == 0);
  endtask

  task automatic send_str(input string s);
    txt.delete();
    for (int k = 0; k < s.len(); k++) txt.push_back(s.getc(k));
    send_txt();
  endtask

  // Hold off until every predicted result has been taken.
  task automatic drain();
    in_tvalid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // key or argument text; an occasional nested {x} exercises the depth count
  task automatic add_body(input int unsigned n, input bit spaced);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        txt.push_back(CH_LBRACE);
        txt.push_back(word_byte());
        txt.push_back(CH_RBRACE);
      end else if (spaced && $urandom_range(0, 5) == 0) begin
        txt.push_back(blank_byte());
      end else begin
        txt.push_back(word_byte());
      end
    end
  endtask

  // Mostly well-formed tags with random content; about a quarter get one
  // byte spoilt and some are cut short so the next first beat restarts.
  task automatic build_tag();
    tag_form_t   form;
    int unsigned idx;
    logic [7:0]  b;
    begin
      txt.delete();
      txt.push_back(CH_LBRACE);
      form = tag_form_t'($urandom_range(0, 2));
      repeat ($urandom_range(0, 6)) txt.push_back(letter());
      if (form != FORM_BARE) begin
        txt.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) txt.push_back(blank_byte());
        if ($urandom_range(0, 7) != 0) add_body($urandom_range(1, 6), 1'b0);
        if (form == FORM_KEY_ARGS) begin
          repeat ($urandom_range(1, 2)) txt.push_back(blank_byte());
          add_body($urandom_range(1, 8), 1'b1);
        end
      end
      txt.push_back(CH_RBRACE);
      if ($urandom_range(0, 3) == 0) begin
        idx = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 5))
          0:       b = CH_NEWLINE;
          1:       b = CH_NUL;
          2:       b = blank_byte();
          3:       b = CH_LBRACE;
          4:       b = CH_COLON;
          default: b = 8'($urandom_range(0, 255));
        endcase
        txt[idx] = b;
      end
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) void'(txt.pop_back());
    end
  endtask

  // {a:kkk...} reaching exactly the length limit, or running one byte past it
  task automatic build_long(input bit closed);
    txt.delete();
    txt.push_back(CH_LBRACE);
    txt.push_back(letter());
    txt.push_back(CH_COLON);
    while (txt.size() < WMTP_MAX_LEN - 1) txt.push_back(letter());
    if (closed) begin
      txt.push_back(CH_RBRACE);
    end else begin
      txt.push_back(letter());
      txt.push_back(letter());
    end
  endtask

  initial begin : stimulus
    int unsigned cand;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tuser   = 1'b0;
    burst_left = 0;
    beats_sent = 0;
    steady     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // beats before any first flag are dropped; byte extremes on the way
    put_byte(CH_NUL, 1'b0);
    put_byte(8'hFF, 1'b0);
    send_str("{}");          // empty bare name
    send_str("x");           // no opening brace: fails on the first beat
    send_str("{a:b c}z");    // key and args; trailing beat after the decision
    send_str("{:}");         // empty key, closed straight after the colon
    send_str("{a\n");        // newline inside the type name
    send_str("{b:");
    put_byte(CH_NUL, 1'b0);  // end of string before the key
    drain();

    cand = 0;
    while (beats_sent < TEXT_BYTES) begin
      if (cand == 30) begin
        build_long(1'b1);
        send_txt();
      end else if (cand == 60) begin
        build_long(1'b0);
        send_txt();
      end else begin
        build_tag();
        send_txt();
        beats_sent += txt.size();
      end
      // after a decision these are ignored; otherwise they extend the scan
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)), 1'b0);
      if (cand % 20 == 0) steady = ($urandom_range(0, 3) == 0);
      if (cand % 150 == 149) drain();
      cand++;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("summary: %0d candidates, %0d beats of random tag text plus two length-limit tags",
             cand + 6, beats_sent);
    $display("summary: %0d results compared, %0d of them recognised tags",
             results_seen, tags_seen);
    if (err_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
